// ===== design/maprof_pkg.sv =====
// shared types, constants and store layout for the memory access profiler
package maprof_pkg;

    // profile store geometry
    localparam int NUM_TYPES   = 8;
    localparam int ADDR_BITS   = 12;
    localparam int MAX_QUERY   = 64;
    localparam int TYPE_SIZE   = 1 << ADDR_BITS;
    localparam int STORE_DEPTH = NUM_TYPES << ADDR_BITS;
    localparam int IDX_W       = $clog2(STORE_DEPTH);

    // item field widths
    localparam int MODE_W      = 3;
    localparam int TYPE_W      = 3;
    localparam int ADDR_W      = 12;
    localparam int STAMP_W     = 64;
    localparam int COUNT_W     = 32;
    localparam int QLEN_W      = 7;
    localparam int STATUS_W    = 3;
    localparam int MASK_W      = 8;

    // stream widths
    localparam int IN_TDATA_W  = 88;
    localparam int OUT_TDATA_W = 288;

    // command queue between front and back
    localparam int Q_DEPTH     = 4;
    localparam int Q_PTR_W     = $clog2(Q_DEPTH);
    localparam int Q_CNT_W     = $clog2(Q_DEPTH + 1);

    // input modes
    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_EXEC  = 3'd2,
        MODE_QUERY = 3'd3,
        MODE_CLEAR = 3'd4
    } t_mode;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        STS_NORMAL      = 3'd0,
        STS_FIRST_UNINIT = 3'd1,
        STS_UNINIT      = 3'd2,
        STS_IGNORED     = 3'd3,
        STS_OOR         = 3'd4,
        STS_CLEAR_DONE  = 3'd5
    } t_status;

    // classified command kinds
    typedef enum logic [2:0] {
        K_READ,
        K_WRITE,
        K_EXEC,
        K_QUERY,
        K_CLEAR,
        K_REJECT
    } t_kind;

    // back end states
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ACC,
        S_QRD,
        S_REPORT
    } t_state;

    // one command as handed from front to back
    typedef struct packed {
        t_kind               kind;
        t_status             status;
        logic                vol;
        logic [IDX_W-1:0]    idx;
        logic [STAMP_W-1:0]  stamp;
        logic [QLEN_W-1:0]   qlen;
    } t_cmd;

    // one store entry, read stamp in the lowest bits
    typedef struct packed {
        logic [COUNT_W-1:0]  exec_count;
        logic [COUNT_W-1:0]  write_count;
        logic [COUNT_W-1:0]  read_count;
        logic [STAMP_W-1:0]  exec_stamp;
        logic [STAMP_W-1:0]  write_stamp;
        logic [STAMP_W-1:0]  read_stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // queue and store clearing status seen by the front
    typedef struct packed {
        logic full;
        logic init_busy;
    } t_front_ctl;

endpackage

// ===== design/maprof_ram.sv =====
// generic single write port, single read port ram with registered read
module maprof_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/maprof_front.sv =====
// front end: volatile mask register, item decode and classification
module maprof_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [maprof_pkg::MASK_W-1:0]       i_cfg_wdata,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [maprof_pkg::IN_TDATA_W-1:0]   i_data,
    input  logic [maprof_pkg::MODE_W-1:0]       i_user,
    input  maprof_pkg::t_front_ctl              i_ctl,
    output logic                                o_push,
    output maprof_pkg::t_cmd                    o_cmd
);
    import maprof_pkg::*;

    logic [MASK_W-1:0]  r_mask;
    logic [TYPE_W-1:0]  f_type;
    logic [ADDR_W-1:0]  f_addr;
    logic               f_addr_valid;
    logic [STAMP_W-1:0] f_stamp;
    logic [QLEN_W-1:0]  f_qlen;
    logic               type_ok;
    logic               addr_ok;
    logic               query_ok;
    t_cmd               cmd;

    // volatile type mask
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_we) begin
            r_mask <= i_cfg_wdata;
        end
    end

    // field unpack
    assign f_type       = i_data[2:0];
    assign f_addr       = i_data[14:3];
    assign f_addr_valid = i_data[15];
    assign f_stamp      = i_data[79:16];
    assign f_qlen       = i_data[86:80];

    // range checks
    assign type_ok  = int'(f_type) < NUM_TYPES;
    assign addr_ok  = int'(f_addr) < TYPE_SIZE;
    assign query_ok = type_ok && (f_qlen != '0) && (int'(f_qlen) <= MAX_QUERY)
                      && ((int'(f_addr) + int'(f_qlen)) <= TYPE_SIZE);

    // classify the item
    always_comb begin
        cmd.kind   = K_REJECT;
        cmd.status = STS_IGNORED;
        cmd.vol    = r_mask[f_type];
        cmd.idx    = (IDX_W'(f_type) << ADDR_BITS) | IDX_W'(f_addr);
        cmd.stamp  = f_stamp;
        cmd.qlen   = f_qlen;
        unique case (i_user)
            MODE_READ, MODE_WRITE, MODE_EXEC: begin
                if (f_addr_valid && type_ok && addr_ok) begin
                    unique case (i_user)
                        MODE_READ:  cmd.kind = K_READ;
                        MODE_WRITE: cmd.kind = K_WRITE;
                        default:    cmd.kind = K_EXEC;
                    endcase
                end
            end
            MODE_QUERY: begin
                if (query_ok) begin
                    cmd.kind = K_QUERY;
                end else begin
                    cmd.status = STS_OOR;
                end
            end
            MODE_CLEAR: cmd.kind = K_CLEAR;
            default:    cmd.kind = K_REJECT;
        endcase
    end

    // hand off to the queue
    assign o_ready = !i_ctl.full && !i_ctl.init_busy;
    assign o_push  = i_valid && o_ready;
    assign o_cmd   = cmd;

endmodule

// ===== design/maprof_queue.sv =====
// short command queue between front and back end
module maprof_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  maprof_pkg::t_cmd i_cmd,
    input  logic             i_pop,
    output maprof_pkg::t_cmd o_cmd,
    output logic             o_empty,
    output logic             o_full
);
    import maprof_pkg::*;

    t_cmd               r_slot [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr;
    logic [Q_CNT_W-1:0] r_count;
    logic               do_push;
    logic               do_pop;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == Q_CNT_W'(Q_DEPTH));
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_cmd   = r_slot[r_rd_ptr];

    // slot storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= Q_PTR_W'((int'(r_wr_ptr) + 1) % Q_DEPTH);
            end
            if (do_pop) begin
                r_rd_ptr <= Q_PTR_W'((int'(r_rd_ptr) + 1) % Q_DEPTH);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== design/maprof_back.sv =====
// back end: store sequencer for access, query and clear, with output register
module maprof_back (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  maprof_pkg::t_cmd                     i_cmd,
    input  logic                                 i_q_empty,
    output logic                                 o_pop,
    output logic                                 o_init_busy,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic [maprof_pkg::OUT_TDATA_W-1:0]   o_data,
    output logic [maprof_pkg::STATUS_W-1:0]      o_user,
    output logic                                 o_last
);
    import maprof_pkg::*;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    t_status            r_status, n_status;
    logic [IDX_W-1:0]   r_clr_idx, n_clr_idx;
    logic               r_clr_rep, n_clr_rep;
    logic               r_init, n_init;
    logic [IDX_W-1:0]   r_q_idx, n_q_idx;
    logic [QLEN_W-1:0]  r_q_left, n_q_left;

    logic               r_out_valid;
    t_entry             r_out_entry;
    t_status            r_out_status;
    logic               r_out_last;

    logic               out_free;
    logic               push;
    t_entry             push_entry;
    t_status            push_status;
    logic               push_last;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_waddr;
    t_entry             ram_wdata;
    logic               ram_re;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;

    // profile store
    maprof_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign out_free = !r_out_valid || i_ready;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_idx <= '0;
            r_clr_rep <= 1'b0;
            r_init    <= 1'b1;
        end else begin
            r_state   <= n_state;
            r_clr_idx <= n_clr_idx;
            r_clr_rep <= n_clr_rep;
            r_init    <= n_init;
        end
    end

    // command payload
    always_ff @(posedge i_clk) begin
        r_cmd    <= n_cmd;
        r_status <= n_status;
        r_q_idx  <= n_q_idx;
        r_q_left <= n_q_left;
    end

    // next state and store control
    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_status    = r_status;
        n_clr_idx   = r_clr_idx;
        n_clr_rep   = r_clr_rep;
        n_init      = r_init;
        n_q_idx     = r_q_idx;
        n_q_left    = r_q_left;
        o_pop       = 1'b0;
        push        = 1'b0;
        push_entry  = '0;
        push_status = STS_NORMAL;
        push_last   = 1'b1;
        ram_we      = 1'b0;
        ram_waddr   = r_cmd.idx;
        ram_wdata   = rd_entry;
        ram_re      = 1'b0;
        ram_raddr   = i_cmd.idx;
        unique case (r_state)
            // zero one entry a cycle
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = r_clr_idx;
                ram_wdata = '0;
                if (r_clr_idx == IDX_W'(STORE_DEPTH - 1)) begin
                    n_init = 1'b0;
                    if (r_clr_rep) begin
                        n_status = STS_CLEAR_DONE;
                        n_state  = S_REPORT;
                    end else begin
                        n_state  = S_IDLE;
                    end
                end else begin
                    n_clr_idx = r_clr_idx + 1'b1;
                end
            end
            // take the next command
            S_IDLE: begin
                if (!i_q_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    unique case (i_cmd.kind)
                        K_REJECT: begin
                            n_status = i_cmd.status;
                            n_state  = S_REPORT;
                        end
                        K_CLEAR: begin
                            n_clr_idx = '0;
                            n_clr_rep = 1'b1;
                            n_state   = S_CLEAR;
                        end
                        K_QUERY: begin
                            ram_re   = 1'b1;
                            n_q_idx  = i_cmd.idx;
                            n_q_left = i_cmd.qlen;
                            n_state  = S_QRD;
                        end
                        default: begin
                            ram_re  = 1'b1;
                            n_state = S_ACC;
                        end
                    endcase
                end
            end
            // update the fetched entry
            S_ACC: begin
                ram_we   = 1'b1;
                n_status = STS_NORMAL;
                unique case (r_cmd.kind)
                    K_READ: begin
                        if (r_cmd.vol && (rd_entry.write_stamp == '0)) begin
                            n_status = (rd_entry.read_stamp == '0) ? STS_FIRST_UNINIT
                                                                   : STS_UNINIT;
                        end
                        ram_wdata.read_stamp = r_cmd.stamp;
                        ram_wdata.read_count = rd_entry.read_count + 1'b1;
                    end
                    K_WRITE: begin
                        ram_wdata.write_stamp = r_cmd.stamp;
                        ram_wdata.write_count = rd_entry.write_count + 1'b1;
                    end
                    default: begin
                        ram_wdata.exec_stamp = r_cmd.stamp;
                        ram_wdata.exec_count = rd_entry.exec_count + 1'b1;
                    end
                endcase
                n_state = S_REPORT;
            end
            // stream out the run of entries
            S_QRD: begin
                if (out_free) begin
                    push       = 1'b1;
                    push_entry = rd_entry;
                    push_last  = (r_q_left == QLEN_W'(1));
                    if (r_q_left == QLEN_W'(1)) begin
                        n_state = S_IDLE;
                    end else begin
                        ram_re    = 1'b1;
                        ram_raddr = r_q_idx + 1'b1;
                        n_q_idx   = r_q_idx + 1'b1;
                        n_q_left  = r_q_left - 1'b1;
                    end
                end
            end
            // single status result
            S_REPORT: begin
                if (out_free) begin
                    push        = 1'b1;
                    push_status = r_status;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_entry  <= push_entry;
            r_out_status <= push_status;
            r_out_last   <= push_last;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_data      = OUT_TDATA_W'(r_out_entry);
    assign o_user      = r_out_status;
    assign o_last      = r_out_last;
    assign o_init_busy = r_init;

endmodule

// ===== design/memory_access_profiler.sv =====
// memory access profiler top level: front end, command queue, back end
// access item: taken from the queue head through fetch, update and report states; one store port
// query item: one entry read from the store per cycle while the output register is free
// clear item: sweeps all NUM_TYPES << ADDR_BITS (32768) store entries, then one result
// reset: synchronous, active low; mask cleared, then a pass clearing all 32768 store entries
//   during which s_axis_tready stays low; configuration writes are taken at any time
module memory_access_profiler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [maprof_pkg::MASK_W-1:0]       i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // mem_type[2:0], address[14:3], address_valid[15], timestamp[79:16],
    // query_length[86:80], zero pad[87]
    input  logic [maprof_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    // mode[2:0]
    input  logic [maprof_pkg::MODE_W-1:0]       s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // read_stamp[63:0], write_stamp[127:64], exec_stamp[191:128],
    // read_count[223:192], write_count[255:224], exec_count[287:256]
    output logic [maprof_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    // status[2:0]
    output logic [maprof_pkg::STATUS_W-1:0]     m_axis_tuser,
    output logic                                m_axis_tlast
);
    import maprof_pkg::*;

    t_front_ctl front_ctl;
    logic       q_push;
    t_cmd       q_in_cmd;
    t_cmd       q_head;
    logic       q_empty;
    logic       q_full;
    logic       q_pop;
    logic       init_busy;

    assign front_ctl.full      = q_full;
    assign front_ctl.init_busy = init_busy;

    // decode and classify
    maprof_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_user      (s_axis_tuser),
        .i_ctl       (front_ctl),
        .o_push      (q_push),
        .o_cmd       (q_in_cmd)
    );

    // command queue
    maprof_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_cmd   (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // store sequencer
    maprof_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (q_head),
        .i_q_empty   (q_empty),
        .o_pop       (q_pop),
        .o_init_busy (init_busy),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (m_axis_tdata),
        .o_user      (m_axis_tuser),
        .o_last      (m_axis_tlast)
    );

endmodule

// ===== tb/tb.sv =====
// self-checking testbench for the memory access profiler
`timescale 1ns / 100ps

module tb;
    import maprof_pkg::*;

    // run control
    localparam int CLK_HALF     = 10;
    localparam int RST_CYCLES   = 7;
    localparam int IDLE_PCT     = 29;
    localparam int HOLD_CYCLES  = 400;
    localparam int SETTLE       = 12;
    localparam int LIMIT_CYCLES = 2_000_000;
    localparam int HOT_SPAN     = 8;
    localparam int MAX_REPORTS  = 30;

    // modes the block rejects
    localparam logic [MODE_W-1:0] MODE_UNUSED_LO = MODE_CLEAR + 1'b1;
    localparam logic [MODE_W-1:0] MODE_UNUSED_HI = '1;

    // one input item, field by field
    typedef struct {
        logic [MODE_W-1:0]  mode;
        logic [TYPE_W-1:0]  mtype;
        logic [ADDR_W-1:0]  addr;
        logic               valid;
        logic [STAMP_W-1:0] stamp;
        logic [QLEN_W-1:0]  qlen;
    } t_access_item;

    // one result item
    typedef struct {
        t_status status;
        t_entry  data;
        logic    last;
    } t_profile_result;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_cfg_we = 1'b0;
    logic [MASK_W-1:0]       i_cfg_wdata = '0;
    logic                    s_axis_tvalid = 1'b0;
    logic                    s_axis_tready;
    // mem_type, address, address_valid, timestamp, query_length, zero pad
    logic [IN_TDATA_W-1:0]   s_axis_tdata = '0;
    // mode
    logic [MODE_W-1:0]       s_axis_tuser = '0;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready = 1'b0;
    // read_stamp, write_stamp, exec_stamp, read_count, write_count, exec_count
    logic [OUT_TDATA_W-1:0]  m_axis_tdata;
    // status
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    m_axis_tlast;

    memory_access_profiler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow profile store and mask
    t_entry            profile_store [int];
    logic [MASK_W-1:0] volatile_mask = '0;

    t_access_item    pending_items [$];
    t_profile_result expected_results [$];
    t_access_item    offered_item;
    logic [ADDR_W-1:0] hot_base [NUM_TYPES];

    logic steady = 1'b0;
    logic hold_arm = 1'b0;
    logic hold_done = 1'b0;
    int   hold_left = 0;

    int mismatches = 0;
    int items_sent = 0;
    int results_seen = 0;
    int query_rows = 0;
    int uninit_reads = 0;
    int clears_seen = 0;
    int cycle_count = 0;

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // append one item to the pending queue
    function automatic void add_item(t_access_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // append one result to the expected queue
    function automatic void add_expect(t_profile_result res);
        expected_results.insert(expected_results.size(), res);
    endfunction

    // expected results of one accepted item
    function automatic void profile_item(t_access_item it);
        t_profile_result res;
        t_entry          ent;
        int              idx;
        logic            vol;
        res.status = STS_NORMAL;
        res.data = '0;
        res.last = 1'b1;
        idx = int'(it.mtype) * TYPE_SIZE + int'(it.addr);
        if (it.mode == MODE_READ || it.mode == MODE_WRITE || it.mode == MODE_EXEC) begin
            if (!it.valid || it.mtype >= NUM_TYPES || it.addr >= TYPE_SIZE) begin
                res.status = STS_IGNORED;
            end else begin
                ent = profile_store.exists(idx) ? profile_store[idx] : '0;
                vol = volatile_mask[it.mtype];
                if (it.mode == MODE_READ) begin
                    if (vol && ent.write_stamp == '0)
                        res.status = (ent.read_stamp == '0) ? STS_FIRST_UNINIT : STS_UNINIT;
                    ent.read_stamp = it.stamp;
                    ent.read_count = ent.read_count + 1'b1;
                end else if (it.mode == MODE_WRITE) begin
                    ent.write_stamp = it.stamp;
                    ent.write_count = ent.write_count + 1'b1;
                end else begin
                    ent.exec_stamp = it.stamp;
                    ent.exec_count = ent.exec_count + 1'b1;
                end
                profile_store[idx] = ent;
            end
            add_expect(res);
        end else if (it.mode == MODE_QUERY) begin
            if (it.mtype >= NUM_TYPES || it.qlen < 1 || it.qlen > MAX_QUERY ||
                int'(it.addr) + int'(it.qlen) > TYPE_SIZE) begin
                res.status = STS_OOR;
                add_expect(res);
            end else begin
                for (int i = 0; i < int'(it.qlen); i++) begin
                    res.data = profile_store.exists(idx + i) ? profile_store[idx + i] : '0;
                    res.last = (i == int'(it.qlen) - 1);
                    add_expect(res);
                end
            end
        end else if (it.mode == MODE_CLEAR) begin
            profile_store.delete();
            res.status = STS_CLEAR_DONE;
            add_expect(res);
        end else begin
            res.status = STS_IGNORED;
            add_expect(res);
        end
    endfunction

    function automatic t_access_item make_item(logic [MODE_W-1:0] mode,
                                               logic [TYPE_W-1:0] mtype,
                                               logic [ADDR_W-1:0] addr,
                                               logic valid,
                                               logic [STAMP_W-1:0] stamp,
                                               logic [QLEN_W-1:0] qlen);
        t_access_item it;
        it.mode = mode;
        it.mtype = mtype;
        it.addr = addr;
        it.valid = valid;
        it.stamp = stamp;
        it.qlen = qlen;
        return it;
    endfunction

    // random item, mostly aimed at a small window per type so entries get reused
    function automatic t_access_item random_item();
        t_access_item it;
        int           pick;
        int           stamp_pick;
        pick = $urandom_range(0, 99);
        stamp_pick = $urandom_range(0, 99);
        it.mtype = TYPE_W'($urandom_range(0, NUM_TYPES - 1));
        it.valid = ($urandom_range(0, 99) >= 6);
        it.qlen = QLEN_W'($urandom);
        if (stamp_pick < 6)
            it.stamp = '0;
        else if (stamp_pick < 10)
            it.stamp = '1;
        else
            it.stamp = {$urandom, $urandom};
        if ($urandom_range(0, 99) < 75)
            it.addr = hot_base[it.mtype] + ADDR_W'($urandom_range(0, HOT_SPAN - 1));
        else
            it.addr = ADDR_W'($urandom);
        if (pick < 32) begin
            it.mode = MODE_READ;
        end else if (pick < 54) begin
            it.mode = MODE_WRITE;
        end else if (pick < 68) begin
            it.mode = MODE_EXEC;
        end else if (pick < 96) begin
            it.mode = MODE_QUERY;
            pick = $urandom_range(0, 99);
            if (pick < 80) begin
                it.addr = hot_base[it.mtype] + ADDR_W'($urandom_range(0, HOT_SPAN - 1));
                it.qlen = QLEN_W'($urandom_range(1, 2 * HOT_SPAN));
            end else if (pick < 87) begin
                it.addr = ADDR_W'($urandom_range(0, TYPE_SIZE - MAX_QUERY));
                it.qlen = QLEN_W'(MAX_QUERY);
            end
        end else begin
            it.mode = MODE_W'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
        end
        return it;
    endfunction

    // fill the pending queue with one random phase, optionally with a clear inside
    task automatic load_random(int count, logic with_clear);
        int clear_at;
        clear_at = with_clear ? $urandom_range(count / 4, count - 1) : -1;
        for (int t = 0; t < NUM_TYPES; t++)
            hot_base[t] = (t == NUM_TYPES - 1) ? ADDR_W'(TYPE_SIZE - HOT_SPAN)
                                               : ADDR_W'($urandom_range(0, TYPE_SIZE - HOT_SPAN));
        for (int i = 0; i < count; i++) begin
            if (i == clear_at)
                add_item(make_item(MODE_CLEAR, '0, '0, 1'b1, '0, '0));
            add_item(random_item());
        end
    endtask

    // wait until every item is sent and every result has come back
    task automatic wait_drained();
        while (pending_items.size() != 0 || s_axis_tvalid || expected_results.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // register write while the block is idle
    task automatic write_mask(logic [MASK_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        volatile_mask = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // sender: predict on acceptance, then offer the next item or idle
    always @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            profile_item(offered_item);
            items_sent++;
        end
        if (!s_axis_tvalid || s_axis_tready) begin
            if (pending_items.size() != 0 &&
                (steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
                offered_item = pending_items.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {1'b0, offered_item.qlen, offered_item.stamp,
                                 offered_item.valid, offered_item.addr, offered_item.mtype};
                s_axis_tuser <= offered_item.mode;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with one long hold-off once armed
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else if (hold_arm && !hold_done) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    function automatic void check_field(string name, logic [STAMP_W-1:0] want,
                                        logic [STAMP_W-1:0] got);
        if (got !== want) begin
            if (mismatches < MAX_REPORTS)
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // result checker against the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
                if (mismatches < MAX_REPORTS)
                    $display("%0t: unexpected result, expected none, actual status %0d",
                             $time, m_axis_tuser);
                mismatches++;
            end else begin
                t_profile_result want;
                t_entry          got;
                want = expected_results.pop_front();
                got = t_entry'(m_axis_tdata);
                check_field("status", want.status, m_axis_tuser);
                check_field("read_stamp", want.data.read_stamp, got.read_stamp);
                check_field("write_stamp", want.data.write_stamp, got.write_stamp);
                check_field("exec_stamp", want.data.exec_stamp, got.exec_stamp);
                check_field("read_count", want.data.read_count, got.read_count);
                check_field("write_count", want.data.write_count, got.write_count);
                check_field("exec_count", want.data.exec_count, got.exec_count);
                check_field("last", want.last, m_axis_tlast);
                if (want.status == STS_NORMAL && want.data != '0)
                    query_rows++;
                if (want.status == STS_FIRST_UNINIT || want.status == STS_UNINIT)
                    uninit_reads++;
                if (want.status == STS_CLEAR_DONE)
                    clears_seen++;
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT_CYCLES) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // reset, then directed and random phases under several masks
    initial begin
        repeat (RST_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // types 0..3 volatile for the directed part
        write_mask(8'h0F);
        add_item(make_item(MODE_READ, 3'd0, 12'd0, 1'b1, 64'd10, 7'd0));
        add_item(make_item(MODE_READ, 3'd0, 12'd0, 1'b1, 64'd11, 7'd0));
        // zero write stamp still reads as never written
        add_item(make_item(MODE_WRITE, 3'd0, 12'd0, 1'b1, 64'd0, 7'd0));
        add_item(make_item(MODE_READ, 3'd0, 12'd0, 1'b1, 64'd12, 7'd0));
        add_item(make_item(MODE_WRITE, 3'd0, 12'd0, 1'b1, 64'd13, 7'd0));
        add_item(make_item(MODE_READ, 3'd0, 12'd0, 1'b1, 64'd14, 7'd0));
        // read stamped zero keeps the entry looking unread
        add_item(make_item(MODE_READ, 3'd1, 12'd5, 1'b1, 64'd0, 7'd0));
        add_item(make_item(MODE_READ, 3'd1, 12'd5, 1'b1, 64'd15, 7'd0));
        // non-volatile type at the top address, all-ones stamps, then one mixed stamp
        add_item(make_item(MODE_READ, 3'd7, 12'hFFF, 1'b1, '1, 7'd0));
        add_item(make_item(MODE_WRITE, 3'd7, 12'hFFF, 1'b1, '1, 7'd0));
        add_item(make_item(MODE_EXEC, 3'd7, 12'hFFF, 1'b1, '1, 7'd0));
        add_item(make_item(MODE_EXEC, 3'd7, 12'hFFF, 1'b1,
                           64'h0123_4567_89AB_CDEF, 7'd0));
        // unmapped addresses are ignored
        add_item(make_item(MODE_READ, 3'd2, 12'd16, 1'b0, 64'd20, 7'd0));
        add_item(make_item(MODE_WRITE, 3'd2, 12'd16, 1'b0, 64'd21, 7'd0));
        add_item(make_item(MODE_EXEC, 3'd2, 12'd16, 1'b0, 64'd22, 7'd0));
        for (int m = MODE_UNUSED_LO; m <= MODE_UNUSED_HI; m++)
            add_item(make_item(MODE_W'(m), 3'd0, 12'd0, 1'b1, 64'd30, 7'd1));
        // queries: single, full length to the end, off the end, bad lengths
        add_item(make_item(MODE_QUERY, 3'd0, 12'd0, 1'b1, '0, 7'd1));
        add_item(make_item(MODE_QUERY, 3'd7, 12'd4032, 1'b1, '0, 7'd64));
        add_item(make_item(MODE_QUERY, 3'd7, 12'd4033, 1'b1, '0, 7'd64));
        add_item(make_item(MODE_QUERY, 3'd3, 12'd0, 1'b1, '0, 7'd0));
        add_item(make_item(MODE_QUERY, 3'd3, 12'd0, 1'b0, '1, 7'd127));
        add_item(make_item(MODE_QUERY, 3'd7, 12'hFFF, 1'b1, '0, 7'd1));
        // clear, then the store reads back empty
        add_item(make_item(MODE_CLEAR, 3'd0, 12'd0, 1'b1, '0, 7'd0));
        add_item(make_item(MODE_QUERY, 3'd0, 12'd0, 1'b1, '0, 7'd2));
        add_item(make_item(MODE_READ, 3'd0, 12'd0, 1'b1, 64'd40, 7'd0));
        wait_drained();

        // all volatile, both sides at full rate
        write_mask(8'hFF);
        steady = 1'b1;
        load_random(100, 1'b0);
        wait_drained();
        steady = 1'b0;

        // nothing volatile, long receiver hold-off, one clear
        write_mask(8'h00);
        load_random(100, 1'b1);
        hold_arm = 1'b1;
        wait_drained();

        write_mask(MASK_W'($urandom));
        load_random(90, 1'b0);
        wait_drained();

        write_mask(8'hA5);
        load_random(90, 1'b1);
        wait_drained();

        $display("sent %0d items, checked %0d results (%0d non-empty entry rows)",
                 items_sent, results_seen, query_rows);
        $display("uninitialized reads %0d, clears %0d, mismatches %0d",
                 uninit_reads, clears_seen, mismatches);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

// ===== memory_access_profiler.f =====
design/maprof_pkg.sv
design/maprof_ram.sv
design/maprof_front.sv
design/maprof_queue.sv
design/maprof_back.sv
design/memory_access_profiler.sv
tb/tb.sv
